// ===== hw/rtl/fbcp_pkg.sv =====
// Shared types and constants for the frame boundary credit pacer.
package fbcp_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned CmdWidth = 2;
  localparam int unsigned OutCountWidth = 5;
  localparam int unsigned OutCreditWidth = 4;
  localparam int unsigned HoldWidth = 2;

  // hold_flags bit that also suppresses a retire
  localparam int unsigned SuppressRetireBit = 1;
  // boundaries needed before the breakpoint goes on
  localparam int unsigned PolicyMin = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_NONE    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2
  } cmd_e;

  // event request into the boundary ring, valid for one cycle
  typedef struct packed {
    logic                 go;      // transaction accepted this cycle
    logic                 push;    // qualified push
    logic                 retire;  // qualified retire
    logic [AddrWidth-1:0] addr;
  } ring_req_t;

  // ring status, valid the cycle after go
  typedef struct packed {
    logic                 overflow;
    logic                 want_on;
    logic [AddrWidth-1:0] want_at;
  } ring_stat_t;

endpackage

// ===== hw/rtl/fbcp_ring.sv =====
// Boundary FIFO memory, head/count/credit registers and second-entry lookup.
module fbcp_ring #(
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned CREDIT_MAX = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fbcp_pkg::ring_req_t                  req_i,
  output fbcp_pkg::ring_stat_t                 stat_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]      count_o,
  output logic [$clog2(CREDIT_MAX+1)-1:0]      credit_o
);

  localparam int unsigned IdxW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CrW  = $clog2(CREDIT_MAX + 1);
  localparam int unsigned SumW = IdxW + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(FIFO_DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(FIFO_DEPTH);
  localparam logic [CrW-1:0]  CrMax  = CrW'(CREDIT_MAX);
  localparam logic [CntW-1:0] PolMin = CntW'(fbcp_pkg::PolicyMin);

  logic [fbcp_pkg::AddrWidth-1:0] mem [FIFO_DEPTH];

  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CrW-1:0]  credit_q, credit_d;
  logic            ovf_q, ovf_d;

  logic [fbcp_pkg::AddrWidth-1:0] rdata_q;
  logic [fbcp_pkg::AddrWidth-1:0] fwd_data_q;
  logic                           fwd_q;

  logic            wr_en;
  logic [SumW-1:0] tail_sum, head_inc, rd_sum;
  logic [IdxW-1:0] tail_idx, head_nxt, rd_idx;

  // ring index arithmetic: sums stay below twice the depth
  always_comb begin
    tail_sum = {1'b0, head_q} + SumW'(count_q);
    tail_idx = (tail_sum >= DepthS) ? IdxW'(tail_sum - DepthS) : IdxW'(tail_sum);
    head_inc = {1'b0, head_q} + SumW'(1);
    head_nxt = (head_inc >= DepthS) ? IdxW'(head_inc - DepthS) : IdxW'(head_inc);
  end

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    credit_d = credit_q;
    ovf_d    = 1'b0;
    wr_en    = 1'b0;
    if (req_i.go && req_i.push) begin
      if (credit_q != '0) begin
        credit_d = credit_q - CrW'(1);
      end else if (count_q == DepthC) begin
        ovf_d = 1'b1;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end else if (req_i.go && req_i.retire) begin
      if (count_q != '0) begin
        head_d  = head_nxt;
        count_d = count_q - CntW'(1);
      end else if (credit_q == CrMax) begin
        ovf_d = 1'b1;
      end else begin
        credit_d = credit_q + CrW'(1);
      end
    end
    rd_sum = {1'b0, head_d} + SumW'(1);
    rd_idx = (rd_sum >= DepthS) ? IdxW'(rd_sum - DepthS) : IdxW'(rd_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      credit_q <= '0;
      ovf_q    <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (req_i.go) begin
      head_q   <= head_d;
      count_q  <= count_d;
      credit_q <= credit_d;
      ovf_q    <= ovf_d;
      // read-during-write on the same entry returns old data: forward
      fwd_q    <= wr_en && (tail_idx == rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_idx] <= req_i.addr;
    end
    if (req_i.go) begin
      rdata_q    <= mem[rd_idx];
      fwd_data_q <= req_i.addr;
    end
  end

  always_comb begin
    stat_o.overflow = ovf_q;
    stat_o.want_on  = (count_q >= PolMin);
    stat_o.want_at  = fwd_q ? fwd_data_q : rdata_q;
  end

  assign count_o  = count_q;
  assign credit_o = credit_q;

endmodule

// ===== hw/rtl/frame_boundary_credit_pacer.sv =====
// Top level of the frame boundary credit pacer.
//
// Tracks frame-end boundaries against completion tokens. A push transaction
// (mode 0) with clear hold flags and a nonzero address uses up a banked
// credit or appends the address to the boundary FIFO; a retire transaction
// (mode 1) with suppress clear and a matching token pops the oldest boundary
// or banks a credit. Full FIFO or saturated credits drop the event and set
// overflow. After every transaction the breakpoint is wanted at the second
// oldest boundary when two or more are outstanding, else off; command reports
// enable or disable only when the applied state changes. Every input
// transaction yields exactly one result transaction. The accept cycle
// updates the counters, writes the FIFO memory and issues the read of the
// second entry; the evaluate state uses the registered read data to
// evaluate the breakpoint and load the output register. An input
// transaction is taken while a previous result still waits; the evaluate
// cycle stalls only if that result has not left yet.
// No clearing pass is needed after reset.
module frame_boundary_credit_pacer #(
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned CREDIT_MAX = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic [fbcp_pkg::AddrWidth-1:0]       boundary_address_i,
  input  logic [fbcp_pkg::HoldWidth-1:0]       hold_flags_i,
  input  logic                                 token_matches_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fbcp_pkg::CmdWidth-1:0]        command_o,
  output logic [fbcp_pkg::AddrWidth-1:0]       breakpoint_address_o,
  output logic                                 breakpoint_on_o,
  output logic [fbcp_pkg::OutCountWidth-1:0]   outstanding_count_o,
  output logic [fbcp_pkg::OutCreditWidth-1:0]  credit_count_o,
  output logic                                 overflow_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q;

  fbcp_pkg::ring_req_t  req;
  fbcp_pkg::ring_stat_t stat;
  logic [$clog2(FIFO_DEPTH+1)-1:0] count;
  logic [$clog2(CREDIT_MAX+1)-1:0] credit;

  logic                           applied_on_q;
  logic [fbcp_pkg::AddrWidth-1:0] applied_addr_q;
  logic                           out_valid_q;

  // result register
  logic [fbcp_pkg::CmdWidth-1:0]       command_q;
  logic [fbcp_pkg::AddrWidth-1:0]      bp_addr_q;
  logic                                bp_on_q;
  logic [fbcp_pkg::OutCountWidth-1:0]  out_count_q;
  logic [fbcp_pkg::OutCreditWidth-1:0] out_credit_q;
  logic                                overflow_q;

  logic in_fire;
  logic eval_go;
  logic same_state;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // qualify the event; ignored events still produce a result
  always_comb begin
    req.go     = in_fire;
    req.push   = !mode_i && (hold_flags_i == '0) && (boundary_address_i != '0);
    req.retire = mode_i && !hold_flags_i[fbcp_pkg::SuppressRetireBit] && token_matches_i;
    req.addr   = boundary_address_i;
  end

  fbcp_ring #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .CREDIT_MAX(CREDIT_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .stat_o  (stat),
    .count_o (count),
    .credit_o(credit)
  );

  // output register must be free (or leaving) before a new result lands
  assign eval_go = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);

  assign same_state = (stat.want_on == applied_on_q) &&
                      (!stat.want_on || (stat.want_at == applied_addr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      applied_on_q   <= 1'b0;
      applied_addr_q <= '0;
      out_valid_q    <= 1'b0;
      command_q      <= fbcp_pkg::CMD_NONE;
      bp_addr_q      <= '0;
      bp_on_q        <= 1'b0;
      out_count_q    <= '0;
      out_credit_q   <= '0;
      overflow_q     <= 1'b0;
    end else begin
      // a new result may land in the cycle the old one leaves
      if (eval_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            state_q <= ST_IDLE;
            if (same_state) begin
              command_q <= fbcp_pkg::CMD_NONE;
              bp_addr_q <= applied_addr_q;
              bp_on_q   <= applied_on_q;
            end else begin
              applied_on_q   <= stat.want_on;
              applied_addr_q <= stat.want_on ? stat.want_at : '0;
              bp_on_q        <= stat.want_on;
              bp_addr_q      <= stat.want_on ? stat.want_at : '0;
              command_q      <= stat.want_on ? fbcp_pkg::CMD_ENABLE
                                             : fbcp_pkg::CMD_DISABLE;
            end
            out_count_q  <= fbcp_pkg::OutCountWidth'(count);
            out_credit_q <= fbcp_pkg::OutCreditWidth'(credit);
            overflow_q   <= stat.overflow;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign command_o            = command_q;
  assign breakpoint_address_o = bp_addr_q;
  assign breakpoint_on_o      = bp_on_q;
  assign outstanding_count_o  = out_count_q;
  assign credit_count_o       = out_credit_q;
  assign overflow_o           = overflow_q;

endmodule
